/* rtl/semaphore_wait_queue_table_top_macros.svh */
// Assertion macros for the semaphore wait queue table.
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_TOP_MACROS_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SWQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SWQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/swq_pkg.sv */
// Package with shared types and constants of the semaphore wait queue table.
`default_nettype none
package swq_pkg;
    localparam int NumProcs = 16;
    localparam int PidW     = 4;
    localparam int KeyW     = 32;

    typedef enum logic [1:0] {
        OP_BLOCK   = 2'd0,
        OP_UNBLK   = 2'd1,
        OP_UNNAMED = 2'd2,
        OP_PEEK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]      operation;
        logic [KeyW-1:0] sem_addr;
        logic [PidW-1:0] proc_id;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic            proc_valid;
        logic [PidW-1:0] result_proc;
    } t_rsp;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_op             op;
        logic [PidW-1:0] pid;
        logic [PidW-1:0] desc;
        logic            hit;
        logic            free_ok;
        logic [KeyW-1:0] key;
    } t_cmd;
endpackage
`default_nettype wire

/* rtl/swq_if.sv */
// Valid/ready channel interface carrying one beat of payload.
`default_nettype none
interface swq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/semaphore_wait_queue_table_top.sv */
// Top level of the semaphore wait queue table.
// Each request beat is registered and its key searched against the active
// descriptors in the front end, then the back end reads the link tables,
// writes them and presents one response beat. The back end steps through its
// read, write and respond states for one request at a time, while the front
// end already holds the next.
`default_nettype none
`include "semaphore_wait_queue_table_top_macros.svh"
module semaphore_wait_queue_table_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    swq_if.sink       i_req,
    swq_if.source     o_rsp
);
    import swq_pkg::*;

    logic                cmd_valid;
    logic                cmd_ready;
    t_cmd                cmd;
    logic [NumProcs-1:0] active;
    logic [KeyW-1:0]     keys [NumProcs];

    swq_front u_front (
        .i_clk, .i_rst_n,
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_req      (i_req.data),
        .i_active   (active),
        .i_keys     (keys),
        .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready),
        .o_cmd      (cmd)
    );

    swq_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready),
        .i_cmd      (cmd),
        .o_active   (active),
        .o_keys     (keys),
        .o_rsp_valid(o_rsp.valid),
        .i_rsp_ready(o_rsp.ready),
        .o_rsp      (o_rsp.data)
    );

    `SWQ_ASSERT_IMP(a_rsp_valid_proc, i_clk, i_rst_n, o_rsp.valid && !o_rsp.data.proc_valid, o_rsp.data.result_proc == '0, "result process not zero")
    `SWQ_ASSERT_IMP(a_full_no_proc, i_clk, i_rst_n, o_rsp.valid && o_rsp.data.status == ST_FULL, !o_rsp.data.proc_valid, "full status carries a process")
    `SWQ_ASSERT_NXT(a_cmd_taken, i_clk, i_rst_n, cmd_valid && cmd_ready, !cmd_ready, "back end took two commands")
endmodule
`default_nettype wire

/* rtl/swq_front.sv */
// Front end: registers a request and searches the descriptor keys.
`default_nettype none
module swq_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire swq_pkg::t_req                i_req,
    input  wire logic [swq_pkg::NumProcs-1:0] i_active,
    input  wire logic [swq_pkg::KeyW-1:0]     i_keys [swq_pkg::NumProcs],
    output logic                              o_cmd_valid,
    input  wire logic                         i_cmd_ready,
    output swq_pkg::t_cmd                     o_cmd
);
    import swq_pkg::*;

    logic r_full;
    t_req r_req;
    logic n_hit;
    logic n_free_ok;
    logic [PidW-1:0] n_hit_d;
    logic [PidW-1:0] n_free_d;

    assign o_in_ready  = !r_full;
    assign o_cmd_valid = r_full;

    // Key match and lowest free descriptor search.
    always_comb begin
        n_hit = 1'b0;
        n_hit_d = '0;
        n_free_ok = 1'b0;
        n_free_d = '0;
        for (int d = NumProcs - 1; d >= 0; d--) begin
            if (i_active[d] && i_keys[d] == r_req.sem_addr) begin
                n_hit = 1'b1;
                n_hit_d = PidW'(d);
            end
            if (!i_active[d]) begin
                n_free_ok = 1'b1;
                n_free_d = PidW'(d);
            end
        end
    end

    always_comb begin
        o_cmd.op      = t_op'(r_req.operation);
        o_cmd.pid     = r_req.proc_id;
        o_cmd.hit     = n_hit;
        o_cmd.free_ok = n_free_ok;
        o_cmd.desc    = n_hit ? n_hit_d : n_free_d;
        o_cmd.key     = r_req.sem_addr;
    end

    // Holding register for one request beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_full <= 1'b1;
        end else if (i_cmd_ready) begin
            r_full <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_req <= i_req;
        end
    end
endmodule
`default_nettype wire

/* rtl/swq_back.sv */
// Back end: sequencer that updates the descriptor and link tables.
`default_nettype none
module swq_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    output logic                              o_cmd_ready,
    input  wire swq_pkg::t_cmd                i_cmd,
    output logic [swq_pkg::NumProcs-1:0]      o_active,
    output logic [swq_pkg::KeyW-1:0]          o_keys [swq_pkg::NumProcs],
    output logic                              o_rsp_valid,
    input  wire logic                         i_rsp_ready,
    output swq_pkg::t_rsp                     o_rsp
);
    import swq_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE, S_RESP} t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [NumProcs-1:0] r_active;
    logic [NumProcs-1:0] r_blocked;
    logic [KeyW-1:0] r_key  [NumProcs];
    logic [PidW-1:0] r_head [NumProcs];
    logic [PidW-1:0] r_tail [NumProcs];
    logic [PidW-1:0] r_next [NumProcs];
    logic [PidW-1:0] r_prev [NumProcs];
    logic [PidW-1:0] r_pdesc[NumProcs];
    // Operands fetched in the read step.
    logic [PidW-1:0] r_d, r_p, r_nx, r_pv, r_hd, r_tl;
    logic            r_go;
    t_rsp            r_rsp;
    logic            n_go;
    t_rsp            n_rsp;

    assign o_active    = r_active;
    assign o_keys      = r_key;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RESP);
    assign o_rsp       = r_rsp;

    // Decide whether the command changes the tables and what it answers.
    always_comb begin
        n_go  = 1'b0;
        n_rsp = '{status: ST_MISS, proc_valid: 1'b0, result_proc: '0};
        case (r_cmd.op)
            OP_BLOCK: begin
                if (!r_blocked[r_cmd.pid]) begin
                    if (r_cmd.hit || r_cmd.free_ok) begin
                        n_go         = 1'b1;
                        n_rsp.status = ST_OK;
                    end else begin
                        n_rsp.status = ST_FULL;
                    end
                end
            end
            OP_UNBLK, OP_PEEK: begin
                if (r_cmd.hit) begin
                    n_go  = (r_cmd.op == OP_UNBLK);
                    n_rsp = '{status: ST_OK, proc_valid: 1'b1,
                              result_proc: r_head[r_cmd.desc]};
                end
            end
            default: begin
                if (r_blocked[r_cmd.pid]) begin
                    n_go  = 1'b1;
                    n_rsp = '{status: ST_OK, proc_valid: 1'b1, result_proc: r_cmd.pid};
                end
            end
        endcase
    end

    // Read, decide, write and respond sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_blocked <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_go  <= n_go;
                    r_rsp <= n_rsp;
                    case (r_cmd.op)
                        OP_BLOCK: begin
                            r_d <= r_cmd.desc;
                            r_p <= r_cmd.pid;
                            r_tl <= r_tail[r_cmd.desc];
                        end
                        OP_UNBLK, OP_PEEK: begin
                            r_d <= r_cmd.desc;
                            r_p <= r_head[r_cmd.desc];
                            r_nx <= r_next[r_head[r_cmd.desc]];
                            r_pv <= r_prev[r_head[r_cmd.desc]];
                            r_hd <= r_head[r_cmd.desc];
                            r_tl <= r_tail[r_cmd.desc];
                        end
                        default: begin
                            r_d <= r_pdesc[r_cmd.pid];
                            r_p <= r_cmd.pid;
                            r_nx <= r_next[r_cmd.pid];
                            r_pv <= r_prev[r_cmd.pid];
                            r_hd <= r_head[r_pdesc[r_cmd.pid]];
                            r_tl <= r_tail[r_pdesc[r_cmd.pid]];
                        end
                    endcase
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (r_go) begin
                        if (r_cmd.op == OP_BLOCK) begin
                            if (!r_cmd.hit) begin
                                r_active[r_d] <= 1'b1;
                                r_key[r_d]    <= r_cmd.key;
                                r_head[r_d]   <= r_p;
                            end else begin
                                r_next[r_tl] <= r_p;
                                r_prev[r_p]  <= r_tl;
                            end
                            r_tail[r_d]    <= r_p;
                            r_blocked[r_p] <= 1'b1;
                            r_pdesc[r_p]   <= r_d;
                        end else begin
                            // Unlink the process from its queue.
                            if (r_hd == r_p && r_tl == r_p) begin
                                r_active[r_d] <= 1'b0;
                            end else begin
                                if (r_hd == r_p) begin
                                    r_head[r_d] <= r_nx;
                                end else begin
                                    r_next[r_pv] <= r_nx;
                                end
                                if (r_tl == r_p) begin
                                    r_tail[r_d] <= r_pv;
                                end else begin
                                    r_prev[r_nx] <= r_pv;
                                end
                            end
                            r_blocked[r_p] <= 1'b0;
                        end
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_rsp_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
